### rtl/cdcur_pkg.sv
// Calendar date cursor package: field widths, reset values, item and result records.
// Date arithmetic helpers: leap year and month length for front and back, weekday pieces for back.
// No dependencies.
package cdcur_pkg;

	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned STEP_W  = 4;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned SUM_W   = 13;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [YEAR_W-1:0]  YEAR_LOW_RESET  = 12'd1900;
	localparam logic [YEAR_W-1:0]  YEAR_HIGH_RESET = 12'd2100;
	localparam logic [YEAR_W-1:0]  YEAR_RESET      = 12'd2000;
	localparam logic [MONTH_W-1:0] MONTH_RESET     = 4'd1;
	localparam logic [DAY_W-1:0]   DAY_RESET       = 5'd1;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef enum logic [1:0] {
		KIND_STEP      = 2'd0,
		KIND_SET_DATE  = 2'd1,
		KIND_SET_YEAR  = 2'd2,
		KIND_SET_MONTH = 2'd3
	} kind_t;

	typedef enum logic {
		CFG_YEAR_LOW  = 1'b0,
		CFG_YEAR_HIGH = 1'b1
	} cfg_index_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [STEP_W-1:0]  step;
		logic [YEAR_W-1:0]         year;
		logic [MONTH_W-1:0]        month;
		logic [DAY_W-1:0]          day;
		logic                      year_ok;
		logic                      month_ok;
		logic                      day_ok;
		logic                      year_leap;
	} item_t;

	localparam int unsigned ITEM_W = $bits(item_t);

	typedef struct packed {
		logic                 month_changed;
		logic                 accepted;
		logic [DAY_W-1:0]     month_length;
		logic [WDAY_W-1:0]    first_weekday;
		logic [WDAY_W-1:0]    day_weekday;
		logic [DAY_W-1:0]     cur_day;
		logic [MONTH_W-1:0]   cur_month;
		logic [YEAR_W-1:0]    cur_year;
	} result_t;

	// floor(x / 100) for x below 43699
	function automatic logic [6:0] div100(input logic [SUM_W-1:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd5243;
		return p[25:19];
	endfunction

	// x mod 7 for x below 8192
	function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] x);
		logic [26:0]       p;
		logic [SUM_W-1:0]  q;
		logic [SUM_W-1:0]  r;
		p = 27'(x) * 27'd9363;
		q = SUM_W'(p[26:16]);
		r = x - q * 13'd7;
		return r[WDAY_W-1:0];
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [6:0]        q;
		logic [SUM_W-1:0]  r;
		q = div100(SUM_W'(y));
		r = SUM_W'(y) - SUM_W'(q) * 13'd100;
		return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2:                     n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

	// 2*mm + floor(3*(mm+1)/5), January and February as months 13 and 14
	function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [5:0] o;
		case (m)
			4'd1:    o = 6'd34;
			4'd2:    o = 6'd37;
			4'd3:    o = 6'd8;
			4'd4:    o = 6'd11;
			4'd5:    o = 6'd13;
			4'd6:    o = 6'd16;
			4'd7:    o = 6'd18;
			4'd8:    o = 6'd21;
			4'd9:    o = 6'd24;
			4'd10:   o = 6'd26;
			4'd11:   o = 6'd29;
			default: o = 6'd31;
		endcase
		return o;
	endfunction

endpackage

### rtl/calendar_date_cursor_top.sv
// Calendar date cursor top level: stream ports, year bound registers, front, queue, back.
// Depends on cdcur_pkg, cdcur_front, cdcur_queue, cdcur_back.
//
// Holds one Gregorian date (reset 2000-01-01) and answers every input transaction with
// exactly one result: the date after the item, its weekday, the weekday of day 1
// (Sunday = 0), the month length and two flags. A transaction can be accepted on every
// clock cycle; a result passes from the item queue through the back-end stages s1, s2 and
// s3, the output register. The rate is set by the date update in the back end, where each
// item reads the date the previous item left. The item queue holds QUEUE_DEPTH entries
// and takes up the slack while a result waits to be taken; once it is full, s_tready
// drops until the output moves again. The user must write year bounds through the cfg
// port only while no transaction is in flight; the block itself does not enforce it.
module calendar_date_cursor_top #(
	parameter int unsigned QUEUE_DEPTH = cdcur_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,  // step_days, new_year, new_month, new_day
	input  logic [1:0]                    s_tuser,  // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cur_year, cur_month, cur_day, day_weekday, first_weekday, month_length,
	// accepted, month_changed
	output logic [39:0]                   m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [cdcur_pkg::YEAR_W-1:0]  cfg_wdata
);

	logic [cdcur_pkg::YEAR_W-1:0] year_low_q;
	logic [cdcur_pkg::YEAR_W-1:0] year_high_q;

	logic                         q_ready;
	logic                         q_push;
	cdcur_pkg::item_t             push_item;
	logic                         q_valid;
	logic                         q_pop;
	cdcur_pkg::item_t             head_item;
	cdcur_pkg::result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_low_q  <= cdcur_pkg::YEAR_LOW_RESET;
			year_high_q <= cdcur_pkg::YEAR_HIGH_RESET;
		end else if (cfg_we) begin
			case (cdcur_pkg::cfg_index_t'(cfg_index))
				cdcur_pkg::CFG_YEAR_LOW:  year_low_q  <= cfg_wdata;
				cdcur_pkg::CFG_YEAR_HIGH: year_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	cdcur_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.year_low  (year_low_q),
		.year_high (year_high_q),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	cdcur_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (cdcur_pkg::ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (head_item)
	);

	cdcur_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.year_low  (year_low_q),
		.year_high (year_high_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (res)
	);

	assign m_tdata = {6'd0, res.month_changed, res.accepted, res.month_length,
		res.first_weekday, res.day_weekday, res.cur_day, res.cur_month, res.cur_year};

	a_ignored_keeps_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.accepted |-> !res.month_changed)
		else $error("ignored item changed the month");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.cur_month >= cdcur_pkg::MONTH_JAN) &&
			(res.cur_month <= cdcur_pkg::MONTH_DEC))
		else $error("month out of range");

	a_day_fits_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.cur_day != '0) && (res.cur_day <= res.month_length))
		else $error("day beyond month length");

endmodule

### rtl/cdcur_front.sv
// Calendar date cursor front end: unpacks an input transaction and classifies it.
// Checks year bounds, month range, day against month length; flags leap year of new_year.
// Depends on cdcur_pkg.
module cdcur_front (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // step_days, new_year, new_month, new_day
	input  logic [1:0]                        s_tuser,  // kind
	input  logic [cdcur_pkg::YEAR_W-1:0]      year_low,
	input  logic [cdcur_pkg::YEAR_W-1:0]      year_high,
	input  logic                              q_ready,
	output logic                              q_push,
	output cdcur_pkg::item_t                  q_item
);

	logic [cdcur_pkg::YEAR_W-1:0]  ny;
	logic [cdcur_pkg::MONTH_W-1:0] nm;
	logic [cdcur_pkg::DAY_W-1:0]   nd;
	logic                          leap;

	always_comb begin
		ny   = s_tdata[15:4];
		nm   = s_tdata[19:16];
		nd   = s_tdata[24:20];
		leap = cdcur_pkg::is_leap(ny);

		q_item.kind      = cdcur_pkg::kind_t'(s_tuser);
		q_item.step      = s_tdata[3:0];
		q_item.year      = ny;
		q_item.month     = nm;
		q_item.day       = nd;
		q_item.year_ok   = (ny >= year_low) && (ny <= year_high);
		q_item.month_ok  = (nm >= cdcur_pkg::MONTH_JAN) && (nm <= cdcur_pkg::MONTH_DEC);
		q_item.day_ok    = (nd != '0) && (nd <= cdcur_pkg::month_len(nm, leap));
		q_item.year_leap = leap;
	end

	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;

endmodule

### rtl/cdcur_queue.sv
// Calendar date cursor item queue: small register FIFO between front and back end.
// Generic width and depth; no package dependency.
module cdcur_queue #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             ready,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign ready    = (count_q != CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && ready;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/cdcur_back.sv
// Calendar date cursor back end: holds the date, applies one item per cycle while the
// output is not stalled, then computes month length and weekdays over two more stages
// into the output register. Depends on cdcur_pkg.
module cdcur_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  cdcur_pkg::item_t                  q_item,
	output logic                              q_pop,
	input  logic [cdcur_pkg::YEAR_W-1:0]      year_low,
	input  logic [cdcur_pkg::YEAR_W-1:0]      year_high,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output cdcur_pkg::result_t                result
);

	logic [cdcur_pkg::YEAR_W-1:0]   year_q;
	logic [cdcur_pkg::MONTH_W-1:0]  month_q;
	logic [cdcur_pkg::DAY_W-1:0]    day_q;

	logic                           en;
	logic                           leap_cur;
	logic [cdcur_pkg::DAY_W-1:0]    ml_cur;
	logic [cdcur_pkg::DAY_W-1:0]    ml_sel;
	logic signed [6:0]              day_sum;
	logic signed [13:0]             y_step;
	logic [cdcur_pkg::MONTH_W-1:0]  m_step;
	logic [cdcur_pkg::DAY_W-1:0]    d_step;
	logic                           step_ok;
	logic [cdcur_pkg::YEAR_W-1:0]   nxt_year;
	logic [cdcur_pkg::MONTH_W-1:0]  nxt_month;
	logic [cdcur_pkg::DAY_W-1:0]    nxt_day;
	logic                           nxt_acc;

	logic                           valid_s1;
	logic [cdcur_pkg::YEAR_W-1:0]   year_s1;
	logic [cdcur_pkg::MONTH_W-1:0]  month_s1;
	logic [cdcur_pkg::DAY_W-1:0]    day_s1;
	logic                           acc_s1;
	logic                           mchg_s1;

	logic [cdcur_pkg::SUM_W-1:0]    yy;
	logic [6:0]                     q100;

	logic                           valid_s2;
	logic [cdcur_pkg::YEAR_W-1:0]   year_s2;
	logic [cdcur_pkg::MONTH_W-1:0]  month_s2;
	logic [cdcur_pkg::DAY_W-1:0]    day_s2;
	logic                           acc_s2;
	logic                           mchg_s2;
	logic [cdcur_pkg::DAY_W-1:0]    ml_s2;
	logic [cdcur_pkg::SUM_W-1:0]    base_s2;

	logic                           valid_s3;

	assign en    = !valid_s3 || m_tready;
	assign q_pop = en && q_valid;

	always_comb begin
		leap_cur = cdcur_pkg::is_leap(year_q);
		ml_cur   = cdcur_pkg::month_len(month_q, leap_cur);
		day_sum  = $signed({2'b00, day_q}) + $signed({{3{q_item.step[3]}}, q_item.step});

		y_step = $signed({2'b00, year_q});
		m_step = month_q;
		d_step = day_sum[cdcur_pkg::DAY_W-1:0];
		if (day_sum < 7'sd1) begin
			if (month_q == cdcur_pkg::MONTH_JAN) begin
				m_step = cdcur_pkg::MONTH_DEC;
				y_step = y_step - 14'sd1;
			end else begin
				m_step = month_q - 1'b1;
			end
			d_step = cdcur_pkg::month_len(m_step, leap_cur);
		end else if (day_sum > $signed({2'b00, ml_cur})) begin
			d_step = 5'd1;
			if (month_q == cdcur_pkg::MONTH_DEC) begin
				m_step = cdcur_pkg::MONTH_JAN;
				y_step = y_step + 14'sd1;
			end else begin
				m_step = month_q + 1'b1;
			end
		end
		step_ok = (y_step >= $signed({2'b00, year_low})) &&
			(y_step <= $signed({2'b00, year_high}));

		nxt_year  = year_q;
		nxt_month = month_q;
		nxt_day   = day_q;
		nxt_acc   = 1'b0;
		ml_sel    = ml_cur;
		case (q_item.kind)
			cdcur_pkg::KIND_STEP: begin
				if (step_ok) begin
					nxt_year  = y_step[cdcur_pkg::YEAR_W-1:0];
					nxt_month = m_step;
					nxt_day   = d_step;
					nxt_acc   = 1'b1;
				end
			end
			cdcur_pkg::KIND_SET_DATE: begin
				if (q_item.year_ok && q_item.month_ok && q_item.day_ok) begin
					nxt_year  = q_item.year;
					nxt_month = q_item.month;
					nxt_day   = q_item.day;
					nxt_acc   = 1'b1;
				end
			end
			cdcur_pkg::KIND_SET_YEAR: begin
				ml_sel = cdcur_pkg::month_len(month_q, q_item.year_leap);
				if (q_item.year_ok) begin
					nxt_year = q_item.year;
					nxt_day  = (day_q > ml_sel) ? ml_sel : day_q;
					nxt_acc  = 1'b1;
				end
			end
			default: begin
				ml_sel = cdcur_pkg::month_len(q_item.month, leap_cur);
				if (q_item.month_ok) begin
					nxt_month = q_item.month;
					nxt_day   = (day_q > ml_sel) ? ml_sel : day_q;
					nxt_acc   = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		yy = cdcur_pkg::SUM_W'(year_s1) + 13'd400
			- ((month_s1 <= cdcur_pkg::MONTH_FEB) ? 13'd1 : 13'd0);
		q100 = cdcur_pkg::div100(yy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= cdcur_pkg::YEAR_RESET;
			month_q  <= cdcur_pkg::MONTH_RESET;
			day_q    <= cdcur_pkg::DAY_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			if (q_pop) begin
				year_q  <= nxt_year;
				month_q <= nxt_month;
				day_q   <= nxt_day;
			end
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1  <= nxt_year;
			month_s1 <= nxt_month;
			day_s1   <= nxt_day;
			acc_s1   <= nxt_acc;
			mchg_s1  <= (nxt_year != year_q) || (nxt_month != month_q);

			year_s2  <= year_s1;
			month_s2 <= month_s1;
			day_s2   <= day_s1;
			acc_s2   <= acc_s1;
			mchg_s2  <= mchg_s1;
			ml_s2    <= cdcur_pkg::month_len(month_s1, cdcur_pkg::is_leap(year_s1));
			base_s2  <= cdcur_pkg::SUM_W'(cdcur_pkg::month_offset(month_s1)) + yy
				+ (yy >> 2) - cdcur_pkg::SUM_W'(q100)
				+ cdcur_pkg::SUM_W'(q100 >> 2) + 13'd1;

			result.cur_year      <= year_s2;
			result.cur_month     <= month_s2;
			result.cur_day       <= day_s2;
			result.day_weekday   <= cdcur_pkg::mod7(base_s2 + cdcur_pkg::SUM_W'(day_s2));
			result.first_weekday <= cdcur_pkg::mod7(base_s2 + 13'd1);
			result.month_length  <= ml_s2;
			result.accepted      <= acc_s2;
			result.month_changed <= mchg_s2;
		end
	end

	assign m_tvalid = valid_s3;

endmodule

### tb/tb_top.sv
// Testbench for calendar_date_cursor_top: directed and random date items checked against a
// scoreboard that models the date cursor, under random idling on both stream sides.
// Depends on cdcur_pkg and the calendar_date_cursor_top RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 8;

	class date_scoreboard;
		int                 year_lo;
		int                 year_hi;
		int                 year;
		int                 month;
		int                 day;
		cdcur_pkg::result_t expected_dates[$];
		int                 failures;
		int                 items_seen;
		int                 results_checked;

		function new();
			year_lo         = int'(cdcur_pkg::YEAR_LOW_RESET);
			year_hi         = int'(cdcur_pkg::YEAR_HIGH_RESET);
			year            = int'(cdcur_pkg::YEAR_RESET);
			month           = int'(cdcur_pkg::MONTH_RESET);
			day             = int'(cdcur_pkg::DAY_RESET);
			failures        = 0;
			items_seen      = 0;
			results_checked = 0;
		endfunction

		function void set_bounds(int lo, int hi);
			year_lo = lo;
			year_hi = hi;
		endfunction

		function int pending();
			return expected_dates.size();
		endfunction

		function bit year_in_range(int y);
			return y >= year_lo && y <= year_hi;
		endfunction

		function bit leap_year(int y);
			return ((y % 100) != 0 && (y % 4) == 0) || (y % 400) == 0;
		endfunction

		function int days_in_month(int y, int m);
			int n;
			case (m)
				2: begin
					n = leap_year(y) ? 29 : 28;
				end
				4, 6, 9, 11: begin
					n = 30;
				end
				default: begin
					n = 31;
				end
			endcase
			return n;
		endfunction

		// shift by 400 years (whole weeks) so every term stays positive
		function int weekday_at(int y, int m, int d);
			int yy;
			int mm;
			int s;
			yy = y + 400;
			mm = m;
			if (mm <= 2) begin
				mm += 12;
				yy -= 1;
			end
			s = d + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400;
			return (s + 1) % 7;
		endfunction

		function void note_item(cdcur_pkg::kind_t k,
				logic signed [cdcur_pkg::STEP_W-1:0] st,
				logic [cdcur_pkg::YEAR_W-1:0] ny, logic [cdcur_pkg::MONTH_W-1:0] nm,
				logic [cdcur_pkg::DAY_W-1:0] nd);
			int                 y;
			int                 m;
			int                 d;
			int                 len;
			int                 prev_year;
			int                 prev_month;
			bit                 taken;
			cdcur_pkg::result_t r;
			prev_year  = year;
			prev_month = month;
			taken      = 1'b0;
			case (k)
				cdcur_pkg::KIND_STEP: begin
					y = year;
					m = month;
					d = day + int'(st);
					if (d < 1) begin
						m -= 1;
						if (m < 1) begin
							m = 12;
							y -= 1;
						end
						d = (y < 0) ? 31 : days_in_month(y, m);
					end else if (d > days_in_month(year, month)) begin
						m += 1;
						d = 1;
						if (m > 12) begin
							m = 1;
							y += 1;
						end
					end
					if (year_in_range(y)) begin
						year  = y;
						month = m;
						day   = d;
						taken = 1'b1;
					end
				end
				cdcur_pkg::KIND_SET_DATE: begin
					if (year_in_range(int'(ny)) && nm >= 1 && nm <= 12 && nd >= 1 &&
							int'(nd) <= days_in_month(int'(ny), int'(nm))) begin
						year  = int'(ny);
						month = int'(nm);
						day   = int'(nd);
						taken = 1'b1;
					end
				end
				cdcur_pkg::KIND_SET_YEAR: begin
					if (year_in_range(int'(ny))) begin
						year = int'(ny);
						len  = days_in_month(year, month);
						if (day > len)
							day = len;
						taken = 1'b1;
					end
				end
				default: begin
					if (nm >= 1 && nm <= 12) begin
						month = int'(nm);
						len   = days_in_month(year, month);
						if (day > len)
							day = len;
						taken = 1'b1;
					end
				end
			endcase
			r.cur_year      = year[cdcur_pkg::YEAR_W-1:0];
			r.cur_month     = month[cdcur_pkg::MONTH_W-1:0];
			r.cur_day       = day[cdcur_pkg::DAY_W-1:0];
			r.day_weekday   = cdcur_pkg::WDAY_W'(weekday_at(year, month, day));
			r.first_weekday = cdcur_pkg::WDAY_W'(weekday_at(year, month, 1));
			r.month_length  = cdcur_pkg::DAY_W'(days_in_month(year, month));
			r.accepted      = taken;
			r.month_changed = (year != prev_year) || (month != prev_month);
			expected_dates.push_back(r);
			items_seen++;
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("[%0t] mismatch in result %0d, %s: got %0d, want %0d",
				$realtime, results_checked, what, got, want);
			failures++;
		endtask

		task check_result(logic [39:0] data);
			cdcur_pkg::result_t got;
			cdcur_pkg::result_t want;
			got = data[$bits(cdcur_pkg::result_t)-1:0];
			if (expected_dates.size() == 0) begin
				report_mismatch("result with nothing pending, cur_year",
					int'(got.cur_year), 0);
				return;
			end
			want = expected_dates.pop_front();
			results_checked++;
			if (got.cur_year !== want.cur_year)
				report_mismatch("cur_year", int'(got.cur_year), int'(want.cur_year));
			if (got.cur_month !== want.cur_month)
				report_mismatch("cur_month", int'(got.cur_month), int'(want.cur_month));
			if (got.cur_day !== want.cur_day)
				report_mismatch("cur_day", int'(got.cur_day), int'(want.cur_day));
			if (got.day_weekday !== want.day_weekday)
				report_mismatch("day_weekday", int'(got.day_weekday),
					int'(want.day_weekday));
			if (got.first_weekday !== want.first_weekday)
				report_mismatch("first_weekday", int'(got.first_weekday),
					int'(want.first_weekday));
			if (got.month_length !== want.month_length)
				report_mismatch("month_length", int'(got.month_length),
					int'(want.month_length));
			if (got.accepted !== want.accepted)
				report_mismatch("accepted", int'(got.accepted), int'(want.accepted));
			if (got.month_changed !== want.month_changed)
				report_mismatch("month_changed", int'(got.month_changed),
					int'(want.month_changed));
		endtask
	endclass

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [31:0]                   s_tdata   = '0;  // step_days, new_year, new_month, new_day
	logic [1:0]                    s_tuser   = '0;  // kind
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	// cur_year, cur_month, cur_day, day_weekday, first_weekday, month_length,
	// accepted, month_changed
	logic [39:0]                   m_tdata;
	logic                          cfg_we    = 1'b0;
	logic                          cfg_index = 1'b0;
	logic [cdcur_pkg::YEAR_W-1:0]  cfg_wdata = '0;

	date_scoreboard sb = new();

	int burst_left  = 0;
	int rx_cycle    = 0;
	int hold_left   = 0;
	int holds_done  = 0;
	int idle_cycles = 0;

	calendar_date_cursor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	task automatic offer(cdcur_pkg::kind_t k, int st, int y, int m, int d);
		int                                  gap;
		logic signed [cdcur_pkg::STEP_W-1:0] st_f;
		logic [cdcur_pkg::YEAR_W-1:0]        y_f;
		logic [cdcur_pkg::MONTH_W-1:0]       m_f;
		logic [cdcur_pkg::DAY_W-1:0]         d_f;
		st_f = cdcur_pkg::STEP_W'(st);
		y_f  = cdcur_pkg::YEAR_W'(y);
		m_f  = cdcur_pkg::MONTH_W'(m);
		d_f  = cdcur_pkg::DAY_W'(d);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, d_f, m_f, y_f, st_f};
		s_tuser  <= k;
		do @(posedge clk); while (!s_tready);
		sb.note_item(k, st_f, y_f, m_f, d_f);
		burst_left--;
	endtask

	task automatic offer_random();
		cdcur_pkg::kind_t k;
		int               pick;
		int               st;
		int               y;
		int               m;
		int               d;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			k = cdcur_pkg::KIND_STEP;
		else if (pick < 14)
			k = cdcur_pkg::KIND_SET_DATE;
		else if (pick < 17)
			k = cdcur_pkg::KIND_SET_YEAR;
		else
			k = cdcur_pkg::KIND_SET_MONTH;
		// arrow-key steps most of the time
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			case ($urandom_range(0, 3))
				0: st = -7;
				1: st = -1;
				2: st = 1;
				default: st = 7;
			endcase
		end else begin
			st = int'($urandom_range(0, 15)) - 8;
		end
		pick = $urandom_range(0, 9);
		if (pick < 2)
			y = $urandom_range(0, 4095);
		else if (pick < 5)
			y = sb.year_lo + int'($urandom_range(0, 4)) - 2;
		else if (pick < 7)
			y = sb.year_hi + int'($urandom_range(0, 4)) - 2;
		else
			y = sb.year + int'($urandom_range(0, 4)) - 2;
		if (y < 0)
			y = 0;
		if (y > 4095)
			y = 4095;
		if ($urandom_range(0, 19) < 17) begin
			m = $urandom_range(1, 12);
		end else begin
			m = $urandom_range(0, 3);
			if (m > 0)
				m += 12;
		end
		pick = $urandom_range(0, 9);
		if (pick < 5)
			d = $urandom_range(1, 28);
		else if (pick < 8)
			d = $urandom_range(28, 31);
		else
			d = $urandom_range(0, 31);
		offer(k, st, y, m, d);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_bounds(int lo, int hi);
		cfg_we    <= 1'b1;
		cfg_index <= cdcur_pkg::CFG_YEAR_LOW;
		cfg_wdata <= cdcur_pkg::YEAR_W'(lo);
		@(posedge clk);
		cfg_index <= cdcur_pkg::CFG_YEAR_HIGH;
		cfg_wdata <= cdcur_pkg::YEAR_W'(hi);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_bounds(lo, hi);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		rx_cycle++;
		if (holds_done == 0 && sb.results_checked >= 200) begin
			hold_left  = 90;
			holds_done = 1;
		end else if (holds_done == 1 && sb.results_checked >= 380) begin
			hold_left  = 40;
			holds_done = 2;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case ((rx_cycle / 48) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ((rx_cycle % 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no transaction for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, sb.pending());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds, date starts at 2000-01-01
		offer(cdcur_pkg::KIND_STEP, -1, 'hFFF, 'hF, 'h1F);
		offer(cdcur_pkg::KIND_STEP, 1, 0, 0, 0);
		offer(cdcur_pkg::KIND_STEP, 0, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2000, 2, 29);
		offer(cdcur_pkg::KIND_STEP, 7, 0, 0, 0);
		offer(cdcur_pkg::KIND_STEP, -8, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 1900, 2, 29);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2100, 2, 29);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2024, 2, 30);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2024, 4, 31);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2024, 5, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2024, 0, 1);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2024, 13, 1);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 1899, 1, 1);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2101, 1, 1);
		offer(cdcur_pkg::KIND_SET_DATE, 7, 2000, 1, 31);
		offer(cdcur_pkg::KIND_SET_MONTH, 0, 0, 2, 0);
		offer(cdcur_pkg::KIND_SET_YEAR, 0, 2001, 0, 0);
		offer(cdcur_pkg::KIND_SET_YEAR, 0, 4095, 0, 0);
		offer(cdcur_pkg::KIND_SET_MONTH, 0, 0, 15, 0);
		offer(cdcur_pkg::KIND_SET_MONTH, 0, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 2100, 12, 31);
		offer(cdcur_pkg::KIND_STEP, 1, 0, 0, 0);
		offer(cdcur_pkg::KIND_STEP, -7, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 1900, 1, 1);
		offer(cdcur_pkg::KIND_STEP, -1, 0, 0, 0);
		settle();

		// full year range
		write_bounds(0, 4095);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 0, 2, 29);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 0, 1, 1);
		offer(cdcur_pkg::KIND_STEP, -1, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_DATE, 0, 4095, 12, 31);
		offer(cdcur_pkg::KIND_STEP, 1, 0, 0, 0);
		offer(cdcur_pkg::KIND_SET_YEAR, 0, 0, 0, 0);
		repeat (100) offer_random();
		settle();

		// low above high: only set-month gets through
		write_bounds(3000, 1000);
		repeat (40) offer_random();
		settle();

		// narrow window, steps keep hitting the edges
		write_bounds(1999, 2001);
		repeat (120) offer_random();
		settle();

		write_bounds(2024, 2024);
		repeat (60) offer_random();
		settle();

		write_bounds(int'(cdcur_pkg::YEAR_LOW_RESET), int'(cdcur_pkg::YEAR_HIGH_RESET));
		repeat (100) offer_random();
		settle();

		$display("run covered %0d items and %0d checked results over six year-bound settings,",
			sb.items_seen, sb.results_checked);
		$display("including the full range, low above high and a single-year window");
		if (sb.failures == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### sim.f
rtl/cdcur_pkg.sv
rtl/cdcur_front.sv
rtl/cdcur_queue.sv
rtl/cdcur_back.sv
rtl/calendar_date_cursor_top.sv
tb/tb_top.sv
